/* design/sgi_pkg.sv */
// shared widths, register indexes and the geometry sideband type for the segment intersection core
package sgi_pkg;

  localparam int CW      = 24;          // coordinate width, signed Q16.8
  localparam int DW      = CW + 1;      // coordinate difference
  localparam int PW      = 2 * DW;      // cross product term
  localparam int NW      = PW + 1;      // numerator / denominator, signed
  localparam int MW      = PW;          // numerator / denominator magnitude
  localparam int HW      = MW / 2;      // half of a magnitude for split multiply
  localparam int NPW     = MW + DW;     // dividend width
  localparam int QB      = 41;          // quotient bits kept, limit is 2^(QB-1)
  localparam int EW      = QB + 2;      // unsaturated crossing coordinate
  localparam int TW      = 50;          // tolerance register width
  localparam int IW      = 2;           // register index width
  localparam int DIV_LAT = QB + 2;      // divider latency in cycles

  typedef enum logic [IW-1:0] {
    CFG_ON_PATH = 2'd0,
    CFG_PAR_TOL = 2'd1
  } cfg_idx_e;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    coord_t x3;
    coord_t y3;
    coord_t x4;
    coord_t y4;
    logic   par;
    logic   negx;
    logic   negy;
  } geo_t;

endpackage

/* design/segment_intersection_core.sv */
// Segment intersection core, fully pipelined, one segment pair per beat.
// Input channel: in_valid_i with eight signed Q16.8 coordinates, in_stall_o back.
// A beat is taken when in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o with hit_o, cross_x_o, cross_y_o; out_stall_i back.
// Every input beat gives exactly one output beat, in order.
// The pipeline has 4 front stages (differences, products, num/den, magnitudes),
// 43 divider stages (split multiply, dividend assembly, one quotient bit per stage),
// and 2 back stages (offset, box test and saturation into the output register).
// One pair per cycle while the output is not held; divider bit stages set the depth.
// When the output beat is held by out_stall_i the whole pipeline freezes and
// in_stall_o is raised; empty slots upstream still take new beats until then.
// Configuration: cfg_valid_i with cfg_index_i and cfg_data_i, always ready.
// Index 0 is on-path mode, index 1 the parallel tolerance; others are dropped.
// Reset clears both registers and all valid bits; no output beat follows reset.
module segment_intersection_core import sgi_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  coord_t        a_start_x_i,
  input  coord_t        a_start_y_i,
  input  coord_t        a_end_x_i,
  input  coord_t        a_end_y_i,
  input  coord_t        b_start_x_i,
  input  coord_t        b_start_y_i,
  input  coord_t        b_end_x_i,
  input  coord_t        b_end_y_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          hit_o,
  output coord_t        cross_x_o,
  output coord_t        cross_y_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [IW-1:0] cfg_index_i,
  input  logic [TW-1:0] cfg_data_i
);

  logic          mode_q;
  logic [TW-1:0] tol_q;
  logic          en;
  geo_t          pt;
  logic          fv;
  geo_t          fg;
  logic [MW-1:0] nmag, dmag;
  logic [DW-1:0] amx, amy;
  logic [QB-1:0] qx, qy;
  logic          ox, oy;
  logic          vd_q [DIV_LAT];
  geo_t          gd_q [DIV_LAT];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      tol_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ON_PATH: mode_q <= cfg_data_i[0];
        CFG_PAR_TOL: tol_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_comb begin
    pt      = '0;
    pt.x1   = a_start_x_i;
    pt.y1   = a_start_y_i;
    pt.x2   = a_end_x_i;
    pt.y2   = a_end_y_i;
    pt.x3   = b_start_x_i;
    pt.y3   = b_start_y_i;
    pt.x4   = b_end_x_i;
    pt.y4   = b_end_y_i;
  end

  sgi_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .pt_i   (pt),
    .tol_i  (tol_q),
    .vld_o  (fv),
    .geo_o  (fg),
    .nmag_o (nmag),
    .dmag_o (dmag),
    .amx_o  (amx),
    .amy_o  (amy)
  );

  sgi_div u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .nmag_i (nmag),
    .dlt_i  (amx),
    .dmag_i (dmag),
    .q_o    (qx),
    .ovf_o  (ox)
  );

  sgi_div u_div_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .nmag_i (nmag),
    .dlt_i  (amy),
    .dmag_i (dmag),
    .q_o    (qy),
    .ovf_o  (oy)
  );

  // sideband delay line matching the divider depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) vd_q[i] <= 1'b0;
    end else if (en) begin
      vd_q[0] <= fv;
      for (int i = 1; i < DIV_LAT; i++) vd_q[i] <= vd_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gd_q[0] <= fg;
      for (int i = 1; i < DIV_LAT; i++) gd_q[i] <= gd_q[i-1];
    end
  end

  sgi_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (vd_q[DIV_LAT-1]),
    .geo_i     (gd_q[DIV_LAT-1]),
    .qx_i      (qx),
    .ox_i      (ox),
    .qy_i      (qy),
    .oy_i      (oy),
    .mode_i    (mode_q),
    .vld_o     (out_valid_o),
    .hit_o     (hit_o),
    .cross_x_o (cross_x_o),
    .cross_y_o (cross_y_o)
  );

`ifndef SYNTH
  a_nohit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (cross_x_o == '0 && cross_y_o == '0))
    else $error("no-hit beat carries a nonzero coordinate");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  a_parallel_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vd_q[DIV_LAT-1] && gd_q[DIV_LAT-1].par) |=> ##1 (!en || !hit_o || !out_valid_o)
    || !$past(en))
    else $error("parallel pair reported a hit");
`endif

endmodule

/* design/sgi_front.sv */
// front pipeline: differences, cross products, numerator and denominator magnitudes
module sgi_front import sgi_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  geo_t          pt_i,
  input  logic [TW-1:0] tol_i,
  output logic          vld_o,
  output geo_t          geo_o,
  output logic [MW-1:0] nmag_o,
  output logic [MW-1:0] dmag_o,
  output logic [DW-1:0] amx_o,
  output logic [DW-1:0] amy_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  geo_t g1_q, g2_q, g3_q, g4_q;

  logic signed [DW-1:0] dxa_d, dya_d, dxb_d, dyb_d, ex_d, ey_d;
  logic signed [DW-1:0] dxa_q, dya_q, dxb_q, dyb_q, ex_q, ey_q;
  logic signed [DW-1:0] dxa2_q, dya2_q, dxa3_q, dya3_q;
  logic signed [PW-1:0] p1_d, p2_d, p3_d, p4_d;
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [NW-1:0] num_d, den_d, num_q, den_q;
  logic signed [NW-1:0] nabs, dabs;
  logic signed [DW-1:0] xabs, yabs;
  logic [MW-1:0] nmag_q, dmag_q;
  logic [DW-1:0] amx_q, amy_q;
  geo_t g4_d;

  always_comb begin
    dxa_d = $signed({pt_i.x2[CW-1], pt_i.x2}) - $signed({pt_i.x1[CW-1], pt_i.x1});
    dya_d = $signed({pt_i.y2[CW-1], pt_i.y2}) - $signed({pt_i.y1[CW-1], pt_i.y1});
    dxb_d = $signed({pt_i.x4[CW-1], pt_i.x4}) - $signed({pt_i.x3[CW-1], pt_i.x3});
    dyb_d = $signed({pt_i.y4[CW-1], pt_i.y4}) - $signed({pt_i.y3[CW-1], pt_i.y3});
    ex_d  = $signed({pt_i.x1[CW-1], pt_i.x1}) - $signed({pt_i.x3[CW-1], pt_i.x3});
    ey_d  = $signed({pt_i.y1[CW-1], pt_i.y1}) - $signed({pt_i.y3[CW-1], pt_i.y3});
  end

  always_comb begin
    p1_d = PW'(dxb_q) * PW'(ey_q);
    p2_d = PW'(dyb_q) * PW'(ex_q);
    p3_d = PW'(dyb_q) * PW'(dxa_q);
    p4_d = PW'(dxb_q) * PW'(dya_q);
  end

  always_comb begin
    num_d = NW'(p1_q) - NW'(p2_q);
    den_d = NW'(p3_q) - NW'(p4_q);
  end

  always_comb begin
    nabs = num_q[NW-1] ? -num_q : num_q;
    dabs = den_q[NW-1] ? -den_q : den_q;
    xabs = dxa3_q[DW-1] ? -dxa3_q : dxa3_q;
    yabs = dya3_q[DW-1] ? -dya3_q : dya3_q;
    g4_d = g3_q;
    g4_d.par  = dabs[MW-1:0] <= tol_i;
    g4_d.negx = num_q[NW-1] ^ dxa3_q[DW-1] ^ den_q[NW-1];
    g4_d.negy = num_q[NW-1] ^ dya3_q[DW-1] ^ den_q[NW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g1_q   <= pt_i;
      dxa_q  <= dxa_d;
      dya_q  <= dya_d;
      dxb_q  <= dxb_d;
      dyb_q  <= dyb_d;
      ex_q   <= ex_d;
      ey_q   <= ey_d;
      g2_q   <= g1_q;
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      p3_q   <= p3_d;
      p4_q   <= p4_d;
      dxa2_q <= dxa_q;
      dya2_q <= dya_q;
      g3_q   <= g2_q;
      num_q  <= num_d;
      den_q  <= den_d;
      dxa3_q <= dxa2_q;
      dya3_q <= dya2_q;
      g4_q   <= g4_d;
      nmag_q <= nabs[MW-1:0];
      dmag_q <= dabs[MW-1:0];
      amx_q  <= xabs;
      amy_q  <= yabs;
    end
  end

  assign vld_o  = v4_q;
  assign geo_o  = g4_q;
  assign nmag_o = nmag_q;
  assign dmag_o = dmag_q;
  assign amx_o  = amx_q;
  assign amy_o  = amy_q;

endmodule

/* design/sgi_div.sv */
// pipelined restoring divider: split multiply, then one quotient bit per stage
module sgi_div import sgi_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [MW-1:0] nmag_i,
  input  logic [DW-1:0] dlt_i,
  input  logic [MW-1:0] dmag_i,
  output logic [QB-1:0] q_o,
  output logic          ovf_o
);

  logic [HW+DW-1:0] pl_q, ph_q;
  logic [MW-1:0]    dm_q;
  logic [NPW-1:0]   nfull;
  logic [MW-1:0]    top;

  logic [MW-1:0] r_q [QB+1];
  logic [QB-1:0] n_q [QB+1];
  logic [QB-1:0] q_q [QB+1];
  logic [MW-1:0] d_q [QB+1];
  logic          o_q [QB+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= (HW+DW)'(nmag_i[HW-1:0]) * (HW+DW)'(dlt_i);
      ph_q <= (HW+DW)'(nmag_i[MW-1:HW]) * (HW+DW)'(dlt_i);
      dm_q <= dmag_i;
    end
  end

  always_comb begin
    nfull = (NPW'(ph_q) << HW) + NPW'(pl_q);
    top   = MW'(nfull[NPW-1:QB]);
  end

  // quotient at or above 2^QB is clamped anyway
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0] <= top;
      n_q[0] <= nfull[QB-1:0];
      q_q[0] <= '0;
      d_q[0] <= dm_q;
      o_q[0] <= top >= dm_q;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [MW:0] rs, sub;
    logic        ge;
    always_comb begin
      rs  = {r_q[k], n_q[k][QB-1]};
      ge  = rs >= {1'b0, d_q[k]};
      sub = rs - {1'b0, d_q[k]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1] <= ge ? sub[MW-1:0] : rs[MW-1:0];
        n_q[k+1] <= {n_q[k][QB-2:0], 1'b0};
        q_q[k+1] <= {q_q[k][QB-2:0], ge};
        d_q[k+1] <= d_q[k];
        o_q[k+1] <= o_q[k];
      end
    end
  end

  assign q_o   = q_q[QB];
  assign ovf_o = o_q[QB];

endmodule

/* design/sgi_back.sv */
// back pipeline: quotient clamp and offset, box tests, saturation, output register
module sgi_back import sgi_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  geo_t          geo_i,
  input  logic [QB-1:0] qx_i,
  input  logic          ox_i,
  input  logic [QB-1:0] qy_i,
  input  logic          oy_i,
  input  logic          mode_i,
  output logic          vld_o,
  output logic          hit_o,
  output coord_t        cross_x_o,
  output coord_t        cross_y_o
);

  localparam logic [QB-1:0] Lim = QB'(1) << (QB - 1);
  localparam logic signed [EW-1:0] SatHi = EW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] SatLo = -SatHi - EW'(1);

  function automatic logic btw(logic signed [EW-1:0] v, coord_t a, coord_t b);
    logic signed [EW-1:0] ea, eb;
    ea = EW'(a);
    eb = EW'(b);
    return (ea < eb) ? (v >= ea && v <= eb) : (v >= eb && v <= ea);
  endfunction

  function automatic coord_t sat(logic signed [EW-1:0] v);
    logic signed [EW-1:0] c;
    c = (v > SatHi) ? SatHi : ((v < SatLo) ? SatLo : v);
    return c[CW-1:0];
  endfunction

  logic [QB-1:0] qmx, qmy;
  logic signed [EW-1:0] xs_d, ys_d, xs_q, ys_q;
  geo_t g_q;
  logic v1_q, vo_q, hit_q, hit_d;
  logic in_a, in_b;
  coord_t cx_q, cy_q;

  always_comb begin
    qmx  = (ox_i || qx_i > Lim) ? Lim : qx_i;
    qmy  = (oy_i || qy_i > Lim) ? Lim : qy_i;
    xs_d = geo_i.negx ? (EW'(geo_i.x1) - $signed({2'b00, qmx}))
                      : (EW'(geo_i.x1) + $signed({2'b00, qmx}));
    ys_d = geo_i.negy ? (EW'(geo_i.y1) - $signed({2'b00, qmy}))
                      : (EW'(geo_i.y1) + $signed({2'b00, qmy}));
  end

  always_comb begin
    in_a  = btw(xs_q, g_q.x1, g_q.x2) && btw(ys_q, g_q.y1, g_q.y2);
    in_b  = btw(xs_q, g_q.x3, g_q.x4) && btw(ys_q, g_q.y3, g_q.y4);
    hit_d = !g_q.par && (mode_i || (in_a && in_b) ||
            (g_q.x1 == g_q.x2 && btw(ys_q, g_q.y1, g_q.y2) && in_b) ||
            (g_q.x3 == g_q.x4 && btw(ys_q, g_q.y3, g_q.y4) && in_a) ||
            (g_q.y1 == g_q.y2 && btw(xs_q, g_q.x1, g_q.x2) && in_b) ||
            (g_q.y3 == g_q.y4 && btw(xs_q, g_q.x3, g_q.x4) && in_a));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      vo_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xs_q  <= xs_d;
      ys_q  <= ys_d;
      g_q   <= geo_i;
      hit_q <= hit_d;
      cx_q  <= hit_d ? sat(xs_q) : '0;
      cy_q  <= hit_d ? sat(ys_q) : '0;
    end
  end

  assign vld_o     = vo_q;
  assign hit_o     = hit_q;
  assign cross_x_o = cx_q;
  assign cross_y_o = cy_q;

endmodule

/* tb/segment_intersection_core_tb.sv */
// testbench for the segment intersection core: predicted crossings checked beat by beat
module segment_intersection_core_tb import sgi_pkg::*; ();

  localparam int LATENCY   = 49;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_LEN  = 400;
  localparam logic [IW-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [IW-1:0] CFG_SPARE_3 = 2'd3;
  localparam longint CMAX = 8388607;
  localparam longint CMIN = -8388608;
  localparam logic [TW-1:0] TOL_MAX = {TW{1'b1}};

  typedef struct {
    coord_t x1, y1, x2, y2, x3, y3, x4, y4;
  } seg_pair_t;

  typedef struct {
    logic   hit;
    coord_t x;
    coord_t y;
  } crossing_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  coord_t        a_start_x_i = '0, a_start_y_i = '0, a_end_x_i = '0, a_end_y_i = '0;
  coord_t        b_start_x_i = '0, b_start_y_i = '0, b_end_x_i = '0, b_end_y_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic          hit_o;
  coord_t        cross_x_o, cross_y_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [IW-1:0] cfg_index_i = CFG_ON_PATH;
  logic [TW-1:0] cfg_data_i = '0;

  segment_intersection_core dut (.*);

  // predictor copy of the registers
  logic          on_path_q = 1'b0;
  logic [TW-1:0] tol_q = '0;

  crossing_t expected_crossings[$];
  int  failures = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;        // no idling on either side
  bit  hold_req = 1'b0;
  bit  holding = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint quot_offset(longint base, longint n, longint d, longint dv);
    logic [127:0] prod, q;
    longint unsigned qm;
    bit neg;
    prod = 128'(n < 0 ? -n : n) * 128'(d < 0 ? -d : d);
    q    = prod / 128'(dv < 0 ? -dv : dv);
    qm   = (q > 128'(64'd1 << 40)) ? (64'd1 << 40) : q[63:0];
    neg  = (n < 0) ^ (d < 0) ^ (dv < 0);
    return neg ? base - longint'(qm) : base + longint'(qm);
  endfunction

  function automatic bit in_span(longint v, longint a, longint b);
    return (a < b) ? (v >= a && v <= b) : (v >= b && v <= a);
  endfunction

  function automatic coord_t clamp_coord(longint v);
    return coord_t'(v > CMAX ? CMAX : (v < CMIN ? CMIN : v));
  endfunction

  function automatic crossing_t calc_crossing(seg_pair_t p);
    longint x1, y1, x2, y2, x3, y3, x4, y4, num, den, dmag, xs, ys;
    bit in_a, in_b, hit;
    crossing_t r;
    x1 = p.x1; y1 = p.y1; x2 = p.x2; y2 = p.y2;
    x3 = p.x3; y3 = p.y3; x4 = p.x4; y4 = p.y4;
    num  = (x4 - x3) * (y1 - y3) - (y4 - y3) * (x1 - x3);
    den  = (y4 - y3) * (x2 - x1) - (x4 - x3) * (y2 - y1);
    dmag = den < 0 ? -den : den;
    hit  = 1'b0;
    xs = 0;
    ys = 0;
    if (dmag > longint'(tol_q)) begin
      xs   = quot_offset(x1, num, x2 - x1, den);
      ys   = quot_offset(y1, num, y2 - y1, den);
      in_a = in_span(xs, x1, x2) && in_span(ys, y1, y2);
      in_b = in_span(xs, x3, x4) && in_span(ys, y3, y4);
      if (on_path_q || (in_a && in_b)) hit = 1'b1;
      else if ((x1 == x2 && in_span(ys, y1, y2) && in_b) ||
               (x3 == x4 && in_span(ys, y3, y4) && in_a) ||
               (y1 == y2 && in_span(xs, x1, x2) && in_b) ||
               (y3 == y4 && in_span(xs, x3, x4) && in_a)) hit = 1'b1;
    end
    r.hit = hit;
    r.x   = hit ? clamp_coord(xs) : '0;
    r.y   = hit ? clamp_coord(ys) : '0;
    return r;
  endfunction

  // predict on input and config beats, check output beats
  always @(posedge clk_i) begin
    seg_pair_t p;
    crossing_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        p = '{a_start_x_i, a_start_y_i, a_end_x_i, a_end_y_i,
              b_start_x_i, b_start_y_i, b_end_x_i, b_end_y_i};
        expected_crossings.insert(expected_crossings.size(), calc_crossing(p));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_ON_PATH) on_path_q <= cfg_data_i[0];
        else if (cfg_index_i == CFG_PAR_TOL) tol_q <= cfg_data_i;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_crossings.size() == 0) begin
          $error("unexpected result beat");
          failures++;
        end else begin
          e = expected_crossings.pop_front();
          if (hit_o !== e.hit) begin
            $error("hit: expected %0d actual %0d", e.hit, hit_o);
            failures++;
          end
          if (cross_x_o !== e.x) begin
            $error("cross_x: expected %0d actual %0d", e.x, cross_x_o);
            failures++;
          end
          if (cross_y_o !== e.y) begin
            $error("cross_y: expected %0d actual %0d", e.y, cross_y_o);
            failures++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stall bursts and the long hold
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        holding = 1'b1;
        out_stall_i <= 1'b1;
        for (n = 0; n < HOLD_LEN; n++) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
        holding = 1'b0;
        @(posedge clk_i);
      end else if (calm || $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  task automatic send_pair(seg_pair_t p);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    a_start_x_i <= p.x1; a_start_y_i <= p.y1; a_end_x_i <= p.x2; a_end_y_i <= p.y2;
    b_start_x_i <= p.x3; b_start_y_i <= p.y3; b_end_x_i <= p.x4; b_end_y_i <= p.y4;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_crossings.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IW-1:0] idx, logic [TW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 4000)) - 2000);
      default: return coord_t'($signed($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    int mode, shape;
    mode  = $urandom_range(0, 2);
    shape = $urandom_range(0, 9);
    p = '{rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
          rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode)};
    case (shape)
      0: p.x2 = p.x1;                        // vertical a
      1: p.y4 = p.y3;                        // horizontal b
      2: begin p.x2 = p.x1; p.y4 = p.y3; end
      3: begin p.x3 = p.x1; p.y3 = p.y1; end // shared start
      4: begin                               // parallel offset copy
        p.x4 = p.x3 + (p.x2 - p.x1);
        p.y4 = p.y3 + (p.y2 - p.y1);
      end
      5: begin p.x2 = p.x1; p.y2 = p.y1; end // point segment
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_random(int count);
    repeat (count) send_pair(rand_pair());
  endtask

  task automatic test_directed();
    seg_pair_t d[17];
    d = '{
      '{0, 0, 1000, 1000, 0, 1000, 1000, 0},            // plain x crossing
      '{0, 0, 1000, 0, 0, 10, 1000, 10},                // parallel
      '{0, 0, 1000, 1000, 2000, 0, 3000, 1000},         // parallel diagonal
      '{5, 5, 5, 5, 0, 0, 10, 10},                      // degenerate point
      '{100, -500, 100, 500, -300, 0, 300, 0},          // vertical vs horizontal
      '{100, -500, 100, 500, 200, 0, 300, 0},           // crossing off segment b
      '{0, 0, 1000, 1000, 500, 500, 2000, 0},           // touching at an end
      '{0, 0, 10, 0, 20, -5, 20, 5},                    // extension hit only
      '{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN},
      '{CMAX, CMAX, CMAX, CMIN, CMIN, 0, CMAX, 0},
      '{CMIN, 0, CMIN + 1, 1, CMAX, CMIN, CMAX - 1, CMAX}, // far extension
      '{0, 0, 1, CMAX, CMIN, CMIN, CMAX, CMIN + 1},     // big quotient
      '{-1, -1, -1, -1, -1, -1, -1, -1},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX},
      '{10, 10, 10, 90, 0, 50, 5, 50},                  // vertical a, b short
      '{0, 50, 100, 50, 40, 0, 40, 30}                  // horizontal a
    };
    foreach (d[i]) send_pair(d[i]);
    wait_drained();
    write_reg(CFG_ON_PATH, TW'(1));
    foreach (d[i]) send_pair(d[i]);
    wait_drained();
  endtask

  task automatic test_register_sweep();
    logic [TW-1:0] tols[4];
    tols = '{TOL_MAX, TW'(1) << 20, TW'($urandom_range(1, 100000)), '0};
    foreach (tols[i]) begin
      write_reg(CFG_PAR_TOL, tols[i]);
      write_reg(CFG_ON_PATH, TW'(i % 2));
      write_reg(CFG_SPARE_2, TOL_MAX);
      write_reg(CFG_SPARE_3, '0);
      send_random(100);
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    while (!holding) @(posedge clk_i);
    send_random(120);
    wait_drained();
  endtask

  task automatic test_random_mix();
    int k;
    for (k = 0; k < 8; k++) begin
      write_reg(CFG_ON_PATH, TW'($urandom_range(0, 1)));
      write_reg(CFG_PAR_TOL, ($urandom_range(0, 2) == 0) ? TW'($urandom_range(0, 5000)) : '0);
      send_random(100);
      wait_drained();
    end
  endtask

  task automatic test_no_idling();
    calm = 1'b1;
    write_reg(CFG_ON_PATH, '0);
    write_reg(CFG_PAR_TOL, '0);
    send_random(200);
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_sweep();
    test_backpressure();
    test_random_mix();
    test_no_idling();
    if (failures == 0 && expected_crossings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
